// File: rtl/core/sd_spi_command_and_block_engine_unit_assert.svh
// Assertion macros used by the checker module.
`ifndef SD_SPI_COMMAND_AND_BLOCK_ENGINE_UNIT_ASSERT_SVH
`define SD_SPI_COMMAND_AND_BLOCK_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define SDSPI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sdspi check failed");

// next-cycle implication
`define SDSPI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sdspi check failed");

`endif

// File: rtl/core/sdspi_pkg.sv
package sdspi_pkg;

    localparam logic [1:0] OP_SLOT  = 2'd0;
    localparam logic [1:0] OP_CMD   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_WRITE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_R1_ERR   = 2'd1;
    localparam logic [1:0] ST_TIMEOUT  = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    localparam logic [1:0] CFG_RESP_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_TOKEN_LIMIT = 2'd1;
    localparam logic [1:0] CFG_CRC         = 2'd2;

    localparam logic [4:0] PH_IDLE        = 5'd0;
    localparam logic [4:0] PH_FRAME       = 5'd1;
    localparam logic [4:0] PH_R1_START    = 5'd2;
    localparam logic [4:0] PH_R1_WAIT     = 5'd3;
    localparam logic [4:0] PH_CMD_TAIL    = 5'd4;
    localparam logic [4:0] PH_TOKEN_START = 5'd5;
    localparam logic [4:0] PH_TOKEN_WAIT  = 5'd6;
    localparam logic [4:0] PH_READ_DATA   = 5'd7;
    localparam logic [4:0] PH_READ_TAIL   = 5'd8;
    localparam logic [4:0] PH_WR_TOKEN    = 5'd9;
    localparam logic [4:0] PH_WR_DATA     = 5'd10;
    localparam logic [4:0] PH_WR_CRC      = 5'd11;
    localparam logic [4:0] PH_WR_RESP     = 5'd12;
    localparam logic [4:0] PH_BUSY1       = 5'd13;
    localparam logic [4:0] PH_GAP         = 5'd14;
    localparam logic [4:0] PH_BUSY2_START = 5'd15;
    localparam logic [4:0] PH_BUSY2       = 5'd16;

    localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
    localparam logic [5:0] CMD_WRITE_SINGLE = 6'd24;

    localparam logic [7:0] CMD_START_BITS = 8'h40;
    localparam logic [7:0] BYTE_IDLE      = 8'hFF;
    localparam logic [7:0] TOKEN_START    = 8'hFE;
    localparam logic [4:0] DRESP_MASK     = 5'h1F;
    localparam logic [4:0] DRESP_ACCEPT   = 5'h05;

    localparam logic [7:0]  RESP_LIMIT_RST  = 8'd255;
    localparam logic [15:0] TOKEN_LIMIT_RST = 16'hFFFF;
    localparam logic [7:0]  CRC_RST         = 8'h95;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  command_index;
        logic [31:0] argument;
        logic [22:0] block_address;
        logic [7:0]  write_byte;
        logic [7:0]  card_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] send_byte;
        logic       select_card;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       wants_write_byte;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] card_response;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  resp_limit;
        logic [15:0] token_limit;
        logic [7:0]  crc;
    } t_cfg;

    typedef struct packed {
        logic [4:0]  phase;
        logic [1:0]  kind;
        logic [5:0]  cmd;
        logic [31:0] arg;
        logic [15:0] poll;
        logic [7:0]  held;
    } t_state;

endpackage

// File: rtl/core/sdspi_step.sv
module sdspi_step #(
    parameter int BLOCK_BYTES = 512,
    parameter int CW          = $clog2(BLOCK_BYTES + 1)
) (
    input  sdspi_pkg::t_in_item  i_item,
    input  sdspi_pkg::t_state    i_state,
    input  logic [CW-1:0]        i_bcnt,
    input  sdspi_pkg::t_cfg      i_cfg,
    output sdspi_pkg::t_state    o_state,
    output logic [CW-1:0]        o_bcnt,
    output sdspi_pkg::t_out_item o_res
);

    localparam logic [CW-1:0] BLK_END = CW'(BLOCK_BYTES);

    logic [7:0]  cb;
    logic [CW-1:0] bcnt_inc;
    logic [31:0] blk_arg;
    logic [5:0]  new_cmd;
    logic [7:0]  frame_byte;
    logic        fin;
    logic [1:0]  fin_st;

    assign cb       = i_item.card_byte;
    assign bcnt_inc = i_bcnt + CW'(1);
    assign blk_arg  = 32'(i_item.block_address) * 32'(BLOCK_BYTES);

    always_comb begin
        case (i_bcnt[2:0])
            3'd1:    frame_byte = i_state.arg[31:24];
            3'd2:    frame_byte = i_state.arg[23:16];
            3'd3:    frame_byte = i_state.arg[15:8];
            default: frame_byte = i_state.arg[7:0];
        endcase
    end

    always_comb begin
        o_state = i_state;
        o_bcnt  = i_bcnt;
        o_res   = '0;
        o_res.send_byte   = sdspi_pkg::BYTE_IDLE;
        o_res.select_card = 1'b1;
        fin     = 1'b0;
        fin_st  = sdspi_pkg::ST_OK;
        new_cmd = i_item.command_index;

        case (i_state.phase)
            sdspi_pkg::PH_IDLE: begin
                if (i_item.opcode == sdspi_pkg::OP_SLOT) begin
                    o_res.select_card = 1'b0;
                end else begin
                    o_state.kind = i_item.opcode;
                    if (i_item.opcode == sdspi_pkg::OP_CMD) begin
                        new_cmd     = i_item.command_index;
                        o_state.arg = i_item.argument;
                    end else begin
                        new_cmd = (i_item.opcode == sdspi_pkg::OP_READ) ?
                                  sdspi_pkg::CMD_READ_SINGLE : sdspi_pkg::CMD_WRITE_SINGLE;
                        o_state.arg = blk_arg;
                    end
                    o_state.cmd     = new_cmd;
                    o_res.send_byte = {2'b01, new_cmd};
                    o_bcnt          = CW'(1);
                    o_state.phase   = sdspi_pkg::PH_FRAME;
                end
            end
            sdspi_pkg::PH_FRAME: begin
                if (i_bcnt >= CW'(5)) begin
                    o_res.send_byte = i_cfg.crc;
                    o_state.phase   = sdspi_pkg::PH_R1_START;
                end else begin
                    o_res.send_byte = frame_byte;
                    o_bcnt          = bcnt_inc;
                end
            end
            sdspi_pkg::PH_R1_START: begin
                o_state.poll  = '0;
                o_state.phase = sdspi_pkg::PH_R1_WAIT;
            end
            sdspi_pkg::PH_R1_WAIT: begin
                if (cb != sdspi_pkg::BYTE_IDLE || i_state.poll >= {8'd0, i_cfg.resp_limit}) begin
                    o_state.held  = cb;
                    o_state.phase = sdspi_pkg::PH_CMD_TAIL;
                end else begin
                    o_state.poll = i_state.poll + 16'd1;
                end
            end
            sdspi_pkg::PH_CMD_TAIL: begin
                if (i_state.held == sdspi_pkg::BYTE_IDLE) begin
                    fin = 1'b1; fin_st = sdspi_pkg::ST_TIMEOUT;
                end else if (i_state.held != 8'd0) begin
                    fin = 1'b1; fin_st = sdspi_pkg::ST_R1_ERR;
                end else if (i_state.kind == sdspi_pkg::OP_READ) begin
                    o_state.phase = sdspi_pkg::PH_TOKEN_START;
                end else if (i_state.kind == sdspi_pkg::OP_WRITE) begin
                    o_state.phase = sdspi_pkg::PH_WR_TOKEN;
                end else begin
                    fin = 1'b1;
                end
            end
            sdspi_pkg::PH_TOKEN_START: begin
                o_state.poll  = '0;
                o_state.phase = sdspi_pkg::PH_TOKEN_WAIT;
            end
            sdspi_pkg::PH_TOKEN_WAIT: begin
                if (cb == sdspi_pkg::TOKEN_START) begin
                    o_bcnt        = '0;
                    o_state.phase = sdspi_pkg::PH_READ_DATA;
                end else if (i_state.poll >= i_cfg.token_limit) begin
                    fin = 1'b1; fin_st = sdspi_pkg::ST_TIMEOUT;
                end else begin
                    o_state.poll = i_state.poll + 16'd1;
                end
            end
            sdspi_pkg::PH_READ_DATA: begin
                o_res.read_byte  = cb;
                o_res.read_valid = 1'b1;
                if (bcnt_inc >= BLK_END) begin
                    o_bcnt        = '0;
                    o_state.phase = sdspi_pkg::PH_READ_TAIL;
                end else begin
                    o_bcnt = bcnt_inc;
                end
            end
            sdspi_pkg::PH_READ_TAIL: begin
                if (i_bcnt >= CW'(2)) begin
                    fin = 1'b1;
                end else begin
                    o_bcnt = bcnt_inc;
                end
            end
            sdspi_pkg::PH_WR_TOKEN: begin
                o_res.send_byte        = sdspi_pkg::TOKEN_START;
                o_res.wants_write_byte = 1'b1;
                o_bcnt                 = '0;
                o_state.phase          = sdspi_pkg::PH_WR_DATA;
            end
            sdspi_pkg::PH_WR_DATA: begin
                o_res.send_byte = i_item.write_byte;
                if (bcnt_inc >= BLK_END) begin
                    o_bcnt        = '0;
                    o_state.phase = sdspi_pkg::PH_WR_CRC;
                end else begin
                    o_bcnt                 = bcnt_inc;
                    o_res.wants_write_byte = 1'b1;
                end
            end
            sdspi_pkg::PH_WR_CRC: begin
                if (i_bcnt >= CW'(2)) begin
                    o_state.phase = sdspi_pkg::PH_WR_RESP;
                end else begin
                    o_bcnt = bcnt_inc;
                end
            end
            sdspi_pkg::PH_WR_RESP: begin
                o_state.held = cb;
                if ((cb[4:0] & sdspi_pkg::DRESP_MASK) != sdspi_pkg::DRESP_ACCEPT) begin
                    fin = 1'b1; fin_st = sdspi_pkg::ST_REJECTED;
                end else begin
                    o_state.poll  = '0;
                    o_state.phase = sdspi_pkg::PH_BUSY1;
                end
            end
            sdspi_pkg::PH_BUSY1: begin
                if (cb != 8'd0) begin
                    o_state.phase = sdspi_pkg::PH_GAP;
                end else if (i_state.poll >= i_cfg.token_limit) begin
                    fin = 1'b1; fin_st = sdspi_pkg::ST_TIMEOUT;
                end else begin
                    o_state.poll = i_state.poll + 16'd1;
                end
            end
            sdspi_pkg::PH_GAP: begin
                o_res.select_card = 1'b0;
                o_state.phase     = sdspi_pkg::PH_BUSY2_START;
            end
            sdspi_pkg::PH_BUSY2_START: begin
                o_state.phase = sdspi_pkg::PH_BUSY2;
            end
            sdspi_pkg::PH_BUSY2: begin
                if (cb != 8'd0) begin
                    fin = 1'b1;
                end else if (i_state.poll >= i_cfg.token_limit) begin
                    fin = 1'b1; fin_st = sdspi_pkg::ST_TIMEOUT;
                end else begin
                    o_state.poll = i_state.poll + 16'd1;
                end
            end
            default: begin
                o_res.select_card = 1'b0;
                o_state.phase     = sdspi_pkg::PH_IDLE;
            end
        endcase

        if (fin) begin
            o_res.done_res      = 1'b1;
            o_res.status        = fin_st;
            o_res.card_response = o_state.held;
            o_state.phase       = sdspi_pkg::PH_IDLE;
        end
    end

endmodule

// File: rtl/core/sd_spi_command_and_block_engine_unit.sv
// Two register stages: the input register holds an item, the output register its result.
// One item per cycle unless stalled: the sequencer step is one pass between the two registers.
// The input side stalls only while both registers are full and the output side stalls.
// Reset: synchronous, active low; returns to idle, clears sequencer state and both valid flags,
// and loads the register defaults (poll limits 255 and 65535, command CRC 0x95).
module sd_spi_command_and_block_engine_unit #(
    parameter int BLOCK_BYTES = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sdspi_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sdspi_pkg::t_out_item o_out_item,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    localparam int CW = $clog2(BLOCK_BYTES + 1);

    logic                 r_in_valid;
    sdspi_pkg::t_in_item  r_in_item;
    logic                 r_out_valid;
    sdspi_pkg::t_out_item r_out_item;
    sdspi_pkg::t_state    r_state;
    sdspi_pkg::t_state    n_state;
    logic [CW-1:0]        r_bcnt;
    logic [CW-1:0]        n_bcnt;
    sdspi_pkg::t_cfg      r_cfg;
    sdspi_pkg::t_out_item n_out_item;
    logic                 adv;
    logic                 in_take;

    assign adv         = r_in_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall  = r_in_valid & r_out_valid & i_out_stall;
    assign in_take     = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    sdspi_step #(
        .BLOCK_BYTES(BLOCK_BYTES),
        .CW         (CW)
    ) u_step (
        .i_item (r_in_item),
        .i_state(r_state),
        .i_bcnt (r_bcnt),
        .i_cfg  (r_cfg),
        .o_state(n_state),
        .o_bcnt (n_bcnt),
        .o_res  (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_state           <= '0;
            r_bcnt            <= '0;
            r_cfg.resp_limit  <= sdspi_pkg::RESP_LIMIT_RST;
            r_cfg.token_limit <= sdspi_pkg::TOKEN_LIMIT_RST;
            r_cfg.crc         <= sdspi_pkg::CRC_RST;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_bcnt      <= n_bcnt;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sdspi_pkg::CFG_RESP_LIMIT:  r_cfg.resp_limit  <= i_cfg_data[7:0];
                    sdspi_pkg::CFG_TOKEN_LIMIT: r_cfg.token_limit <= i_cfg_data;
                    sdspi_pkg::CFG_CRC:         r_cfg.crc         <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
        if (adv) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

// File: rtl/core/sdspi_checker.sv
`include "sd_spi_command_and_block_engine_unit_assert.svh"

module sdspi_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input sdspi_pkg::t_out_item o_out_item
);

    `SDSPI_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))
    `SDSPI_ASSERT_IMP(a_no_status_midway, i_clk, i_rst_n, o_out_valid && !o_out_item.done_res, o_out_item.status == sdspi_pkg::ST_OK && o_out_item.card_response == 8'd0)
    `SDSPI_ASSERT_IMP(a_read_byte_quiet, i_clk, i_rst_n, o_out_valid && !o_out_item.read_valid, o_out_item.read_byte == 8'd0)
    `SDSPI_ASSERT_IMP(a_deselect_idle_byte, i_clk, i_rst_n, o_out_valid && !o_out_item.select_card, o_out_item.send_byte == sdspi_pkg::BYTE_IDLE && !o_out_item.done_res)

endmodule

bind sd_spi_command_and_block_engine_unit sdspi_checker u_sdspi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);
